// ===== hdl/gradient_norm_clip_macros.svh =====
// assertion macros for the gradient norm clipping block
`ifndef GRADIENT_NORM_CLIP_MACROS_SVH
`define GRADIENT_NORM_CLIP_MACROS_SVH

// condition holds at every clock edge out of reset
`define GNC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("gradient_norm_clip: invariant violated");

// antecedent implies consequent in the same cycle
`define GNC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gradient_norm_clip: implication violated");

`endif

// ===== hdl/gnc_pkg.sv =====
// types and constants for the gradient norm clipping block
`timescale 1ns / 1ps

package gnc_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned NORM_W           = 21;
  localparam int unsigned MAXN_W           = 24;
  localparam int unsigned SCALE_W          = 17;
  localparam int unsigned DIV_STEPS        = 16;

  localparam logic [SCALE_W-1:0] UNITY_SCALE = 17'h10000;
  localparam logic [NORM_W-1:0]  NORM_MAX    = 21'h1FFFFF;

  // mode codes of an input item
  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_APPLY   = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  value_out;
    logic [NORM_W-1:0]   norm;
    logic                clipped;
    logic                last_out;
  } out_item_t;

endpackage

// ===== hdl/gradient_norm_clip.sv =====
// gradient_norm_clip: two-pass l2 norm clipping of a streamed gradient vector
`timescale 1ns / 1ps
`include "gradient_norm_clip_macros.svh"

// Clips a gradient vector of signed Q3.12 elements by its L2 norm in two passes.
// In the measure pass (mode 0) each element adds its square to a saturating
// accumulator (cap MAX_ELEMENTS * 2^30); the last element of the pass yields one
// item with the floor square root norm (saturated to 21 bits) and a clip flag,
// set when norm_limit is nonzero and the norm exceeds it. The scale is then
// floor(norm_limit * 65536 / norm), else unity. In the apply pass (mode 1) every
// element yields value * scale >> 16, truncated toward zero, and the last apply
// element clears the accumulator. A measure element that is not last yields no
// item. Timing: one item at a time, in_ready is high only when the sequencer
// is idle. Apply elements and non-last measure elements pass through accept,
// multiply, and accumulate or output before the next accept. A last measure
// element passes through accept, multiply, accumulate, the square root steps,
// the clip check, the division when clipping, and output. There are RW =
// ceil(($clog2(MAX_ELEMENTS) + 31) / 2) square root steps (RW = 21 for the
// default 1024 elements); one shared compare/subtract unit runs the square
// root two bits a cycle and then the restoring division one quotient bit a
// cycle. One 17x17 multiplier serves both the squaring and the scaling. The
// result register decouples the output: a new item may be accepted while the
// previous result still waits for out_ready, but an element that yields an item
// holds in its output step while the previous result waits. The user writes
// norm_limit via cfg_we/cfg_data only while idle; the block does not enforce it.
module gradient_norm_clip
  import gnc_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [MAXN_W-1:0] cfg_data
);

  // accumulator holds up to MAX_ELEMENTS * 2^30
  localparam int unsigned SW   = $clog2(MAX_ELEMENTS) + 31;
  localparam int unsigned RW   = (SW + 1) / 2;           // root bits
  localparam int unsigned SQW  = 2 * RW;                 // radicand, padded even
  localparam int unsigned DIVW = NORM_W + 1;             // division remainder
  localparam int unsigned UW   = (RW + 2 > DIVW) ? RW + 2 : DIVW;
  localparam int unsigned NXW  = (RW > NORM_W) ? RW : NORM_W;
  localparam int unsigned NIT  = (RW > DIV_STEPS) ? RW : DIV_STEPS;
  localparam int unsigned ITW  = $clog2(NIT);

  localparam logic [SW-1:0] CAP = SW'(MAX_ELEMENTS) << 30;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_ROOT,
    S_CLIP,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state;

  // captured element
  logic                mode_q;
  logic                last_q;
  logic                neg_q;
  logic [16:0]         mag_q;
  logic [33:0]         prod;

  // vector state
  logic [SW-1:0]       square_sum;
  logic [NORM_W-1:0]   held_norm;
  logic [SCALE_W-1:0]  scale_factor;
  logic                clip_active;
  logic [MAXN_W-1:0]   norm_limit;

  // iteration registers of the root / divide sequencer
  logic [SQW-1:0]      rad;
  logic [UW-1:0]       rem;
  logic [RW-1:0]       root;
  logic [14:0]         quo;
  logic [ITW-1:0]      cnt;

  // combinational helpers
  logic [16:0]         mag_in;
  logic [16:0]         mul_b;
  logic [33:0]         mul_p;
  logic [SW:0]         sum_ext;
  logic [SW-1:0]       sum_new;
  logic [UW-1:0]       alu_a;
  logic [UW-1:0]       alu_b;
  logic [UW:0]         alu_diff;
  logic                alu_ge;
  logic [NXW-1:0]      root_ext;
  logic [NORM_W-1:0]   norm_sat;
  logic                clip_now;
  logic [15:0]         scaled_mag;
  logic [15:0]         apply_v;

  assign in_ready = (state == S_IDLE);

  // magnitude of a two's complement element, 0..32768
  assign mag_in = in_item.value[15] ? (17'h10000 - {1'b0, in_item.value})
                                    : {1'b0, in_item.value};

  // shared multiplier: square in measure pass, scale in apply pass
  assign mul_b = (mode_q == MODE_APPLY) ? scale_factor : mag_q;
  assign mul_p = mag_q * mul_b;

  // saturating accumulate, sum never exceeds the cap
  assign sum_ext = {1'b0, square_sum} + (SW + 1)'(prod);
  assign sum_new = (sum_ext >= {1'b0, CAP}) ? CAP : sum_ext[SW-1:0];

  // shared compare/subtract unit: square root step or division step
  always_comb begin
    if (state == S_ROOT) begin
      alu_a = UW'({rem, rad[SQW-1 -: 2]});
      alu_b = UW'({root, 2'b01});
    end else begin
      alu_a = UW'({rem, 1'b0});
      alu_b = UW'(held_norm);
    end
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = ~alu_diff[UW];

  // norm saturates to 21 bits
  assign root_ext = NXW'(root);
  assign norm_sat = (root_ext > NXW'(NORM_MAX)) ? NORM_MAX : root_ext[NORM_W-1:0];
  assign clip_now = (norm_limit != '0) && (MAXN_W'(norm_sat) > norm_limit);

  // (mag * scale) >> 16, low 16 bits, sign restored
  assign scaled_mag = prod[31:16];
  assign apply_v    = neg_q ? (16'h0 - scaled_mag) : scaled_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      square_sum   <= '0;
      held_norm    <= '0;
      scale_factor <= UNITY_SCALE;
      clip_active  <= 1'b0;
      norm_limit   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        norm_limit <= cfg_data;
      end

      // result register: load on emit, clear once taken
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= in_item.mode;
            last_q <= in_item.last;
            neg_q  <= in_item.value[15];
            mag_q  <= mag_in;
            state  <= S_MUL;
          end
        end

        S_MUL: begin
          prod  <= mul_p;
          state <= (mode_q == MODE_APPLY) ? S_EMIT : S_ACC;
        end

        S_ACC: begin
          square_sum <= sum_new;
          if (last_q) begin
            // start the digit-by-digit square root, msb pair first
            rad   <= SQW'(sum_new);
            rem   <= '0;
            root  <= '0;
            cnt   <= ITW'(RW - 1);
            state <= S_ROOT;
          end else begin
            state <= S_IDLE;
          end
        end

        S_ROOT: begin
          rem  <= alu_ge ? alu_diff[UW-1:0] : alu_a;
          root <= {root[RW-2:0], alu_ge};
          rad  <= rad << 2;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_CLIP;
          end
        end

        S_CLIP: begin
          held_norm <= norm_sat;
          if (clip_now) begin
            // norm_limit < norm, so the quotient fits in 16 bits
            rem   <= UW'(norm_limit);
            quo   <= '0;
            cnt   <= ITW'(DIV_STEPS - 1);
            state <= S_DIV;
          end else begin
            clip_active  <= 1'b0;
            scale_factor <= UNITY_SCALE;
            state        <= S_EMIT;
          end
        end

        S_DIV: begin
          rem <= alu_ge ? alu_diff[UW-1:0] : alu_a;
          quo <= {quo[13:0], alu_ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            scale_factor <= {1'b0, quo, alu_ge};
            clip_active  <= 1'b1;
            state        <= S_EMIT;
          end
        end

        S_EMIT: begin
          // wait until the result register is free
          if (!out_valid || out_ready) begin
            out_item.value_out <= (mode_q == MODE_APPLY) ? apply_v : 16'sh0;
            out_item.norm      <= held_norm;
            out_item.clipped   <= clip_active;
            out_item.last_out  <= last_q;
            if (mode_q == MODE_APPLY && last_q) begin
              square_sum <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // accumulator saturation bound
  `GNC_ASSERT_ALWAYS(a_sum_capped, square_sum <= CAP)
  // a latched clip always scales down, no clip means unity scale
  `GNC_ASSERT_IMPLIES(a_clip_scale, clip_active, scale_factor < UNITY_SCALE)
  `GNC_ASSERT_IMPLIES(a_unity_scale, !clip_active, scale_factor == UNITY_SCALE)

endmodule
